// File: hw/rtl/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// shared constants, cofactor index tables and control types for the 3x3
// matrix inverse core
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int THR_WIDTH  = 31;
  localparam int NUM_ELEMS  = 9;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // register index
  localparam int REG_THRESHOLD = 0;

  typedef int idx_arr_t [NUM_ELEMS];

  // cofactor k = e[P]*e[Q] - e[S]*e[T]
  localparam idx_arr_t COF_P = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam idx_arr_t COF_Q = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam idx_arr_t COF_S = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam idx_arr_t COF_T = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic valid;
    logic singular;
    logic dneg;
  } det_ctl_t;

endpackage

// File: hw/rtl/mi3_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_in_if
// input channel: one 3x3 matrix word, row-major
// ----------------------------------------------------------------------------
interface mi3_in_if #(
  parameter int W = mi3_pkg::ELEM_WIDTH
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    input  ready
  );
  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output ready
  );
endinterface

// File: hw/rtl/mi3_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_out_if
// output channel: inverse (or adjugate) word plus ok flag
// ----------------------------------------------------------------------------
interface mi3_out_if #(
  parameter int W = mi3_pkg::ELEM_WIDTH
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
  logic                ok;

  modport source (
    output valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, ok,
    input  ready
  );
  modport sink (
    input  valid, inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22, ok,
    output ready
  );
endinterface

// File: hw/rtl/mi3_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cfg
// apb register port holding the singular threshold
// ----------------------------------------------------------------------------
module mi3_cfg #(
  parameter int AW = mi3_pkg::APB_AW,
  parameter int DW = mi3_pkg::APB_DW,
  parameter int TW = mi3_pkg::THR_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  output logic [DW-1:0] prdata,
  output logic          pready,
  output logic [TW-1:0] thr
);
  logic hit;

  assign hit    = (paddr[AW-1:2] == (AW-2)'(mi3_pkg::REG_THRESHOLD));
  assign pready = 1'b1;
  assign prdata = hit ? DW'(thr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (psel && penable && pwrite && hit) begin
      thr <= pwdata[TW-1:0];
    end
  end
endmodule

// File: hw/rtl/mi3_cof.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cof
// two stages: eighteen element products, then nine exact cofactors
// ----------------------------------------------------------------------------
module mi3_cof #(
  parameter int W = mi3_pkg::ELEM_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   e [mi3_pkg::NUM_ELEMS],
  output logic                  out_valid,
  output logic signed [2*W:0]   cof [mi3_pkg::NUM_ELEMS],
  output logic signed [W-1:0]   row0 [3]
);
  localparam int N  = mi3_pkg::NUM_ELEMS;
  localparam int CW = 2 * W + 1;

  logic                  v1;
  logic signed [2*W-1:0] pa [N];
  logic signed [2*W-1:0] pb [N];
  logic signed [W-1:0]   r1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        pa[k]  <= e[mi3_pkg::COF_P[k]] * e[mi3_pkg::COF_Q[k]];
        pb[k]  <= e[mi3_pkg::COF_S[k]] * e[mi3_pkg::COF_T[k]];
        cof[k] <= CW'(pa[k]) - CW'(pb[k]);
      end
      for (int j = 0; j < 3; j++) begin
        r1[j]   <= e[j];
        row0[j] <= r1[j];
      end
    end
  end
endmodule

// File: hw/rtl/mi3_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det
// three stages: split determinant products, determinant sum, then
// magnitudes, singular test and saturated adjugate
// ----------------------------------------------------------------------------
module mi3_det #(
  parameter int W  = mi3_pkg::ELEM_WIDTH,
  parameter int F  = mi3_pkg::FRAC_BITS,
  parameter int TW = mi3_pkg::THR_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [2*W:0]      cof [mi3_pkg::NUM_ELEMS],
  input  logic signed [W-1:0]      row0 [3],
  input  logic [TW-1:0]            thr,
  output mi3_pkg::det_ctl_t        ctl,
  output logic [3*W-1:0]           dmag,
  output logic [2*W-1:0]           amag [mi3_pkg::NUM_ELEMS],
  output logic                     aneg [mi3_pkg::NUM_ELEMS],
  output logic [W-1:0]             adj [mi3_pkg::NUM_ELEMS]
);
  localparam int N  = mi3_pkg::NUM_ELEMS;
  localparam int CW = 2 * W + 1;
  localparam int PW = 2 * W + 1;
  localparam int DW = 3 * W + 1;
  localparam int DM = 3 * W;
  localparam int XW = DM + TW + 2 * F;
  localparam logic [2*W-1:0] LIMP = (2*W)'({(W-1){1'b1}});
  localparam logic [2*W-1:0] LIMN = LIMP + 1'b1;

  logic                 v3, v4;
  logic signed [PW-1:0] pl [3];
  logic signed [PW-1:0] ph [3];
  logic signed [CW-1:0] c3 [N];
  logic signed [CW-1:0] c4 [N];
  logic signed [DW-1:0] det;
  logic signed [CW-1:0] cof_det [3];

  assign cof_det[0] = cof[0];
  assign cof_det[1] = cof[3];
  assign cof_det[2] = cof[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v3 <= in_valid;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    logic [CW-1:0]   ca;
    logic [2*W-1:0]  v;
    logic [2*W-1:0]  lim;
    logic            ng;
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= v4;
    end
    if (en) begin
      // stage 3: split cofactor into low word and signed high part
      for (int j = 0; j < 3; j++) begin
        pl[j] <= row0[j] * $signed({1'b0, cof_det[j][W-1:0]});
        ph[j] <= row0[j] * $signed(cof_det[j][CW-1:W]);
      end
      c3 <= cof;
      // stage 4: determinant
      det <= (DW'(ph[0]) <<< W) + DW'(pl[0])
           + (DW'(ph[1]) <<< W) + DW'(pl[1])
           + (DW'(ph[2]) <<< W) + DW'(pl[2]);
      c4 <= c3;
      // stage 5: magnitudes, singular test, adjugate in qf
      dmag         <= det[DW-1] ? DM'(-det) : DM'(det);
      ctl.dneg     <= det[DW-1];
      ctl.singular <= XW'(det[DW-1] ? DM'(-det) : DM'(det)) <= (XW'(thr) << (2 * F));
      for (int k = 0; k < N; k++) begin
        ng      = c4[k][CW-1];
        ca      = ng ? -c4[k] : c4[k];
        v       = ca[2*W-1:0] >> F;
        lim     = ng ? LIMN : LIMP;
        if (v > lim) v = lim;
        amag[k] <= ca[2*W-1:0];
        aneg[k] <= ng;
        adj[k]  <= ng ? W'(-v[W-1:0]) : v[W-1:0];
      end
    end
  end
endmodule

// File: hw/rtl/mi3_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div
// nine-lane restoring divider, one quotient bit per stage, with overflow
// detect, saturation and final select onto the output register
// ----------------------------------------------------------------------------
module mi3_div #(
  parameter int W = mi3_pkg::ELEM_WIDTH,
  parameter int F = mi3_pkg::FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  mi3_pkg::det_ctl_t   ctl,
  input  logic [3*W-1:0]      dmag,
  input  logic [2*W-1:0]      amag [mi3_pkg::NUM_ELEMS],
  input  logic                aneg [mi3_pkg::NUM_ELEMS],
  input  logic [W-1:0]        adj [mi3_pkg::NUM_ELEMS],
  output logic                out_valid,
  output logic                ok,
  output logic [W-1:0]        inv [mi3_pkg::NUM_ELEMS]
);
  localparam int N  = mi3_pkg::NUM_ELEMS;
  localparam int DM = 3 * W;
  localparam int NW = 2 * W + 2 * F;
  localparam logic [W-1:0] LIMP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIMN = LIMP + 1'b1;

  mi3_pkg::det_ctl_t cs [W+1];
  logic [DM-1:0]     ds [W+1];
  logic [DM-1:0]     rs [W+1][N];
  logic [W-1:0]      qs [W+1][N];
  logic [W-1:0]      ns [W+1][N];
  logic              os [W+1][N];
  logic              gs [W+1][N];
  logic [W-1:0]      as [W+1][N];
  logic [DM:0]       t  [1:W][N];
  logic              ge [1:W][N];

  // stage 0: overflow check and first partial remainder
  always_ff @(posedge clk) begin
    logic [NW-1:0] num;
    if (rst) begin
      cs[0].valid <= 1'b0;
    end else if (en) begin
      cs[0].valid <= ctl.valid;
    end
    if (en) begin
      cs[0].singular <= ctl.singular;
      cs[0].dneg     <= ctl.dneg;
      ds[0]          <= dmag;
      for (int k = 0; k < N; k++) begin
        num       = NW'(amag[k]) << (2 * F);
        rs[0][k] <= DM'(num[NW-1:W]);
        os[0][k] <= num[NW-1:W] >= dmag;
        ns[0][k] <= num[W-1:0];
        qs[0][k] <= '0;
        gs[0][k] <= aneg[k] ^ ctl.dneg;
        as[0][k] <= adj[k];
      end
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_step
    for (genvar k = 0; k < N; k++) begin : g_lane
      assign t[s][k]  = {rs[s-1][k], ns[s-1][k][W-1]};
      assign ge[s][k] = t[s][k] >= {1'b0, ds[s-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cs[s].valid <= 1'b0;
      end else if (en) begin
        cs[s].valid <= cs[s-1].valid;
      end
      if (en) begin
        cs[s].singular <= cs[s-1].singular;
        cs[s].dneg     <= cs[s-1].dneg;
        ds[s]          <= ds[s-1];
        for (int k = 0; k < N; k++) begin
          rs[s][k] <= ge[s][k] ? DM'(t[s][k] - {1'b0, ds[s-1]}) : DM'(t[s][k]);
          qs[s][k] <= {qs[s-1][k][W-2:0], ge[s][k]};
          ns[s][k] <= {ns[s-1][k][W-2:0], 1'b0};
          os[s][k] <= os[s-1][k];
          gs[s][k] <= gs[s-1][k];
          as[s][k] <= as[s-1][k];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cs[W].valid;
    end
  end

  always_ff @(posedge clk) begin
    logic [W-1:0] m;
    logic [W-1:0] lim;
    if (en) begin
      ok <= !cs[W].singular;
      for (int k = 0; k < N; k++) begin
        lim = gs[W][k] ? LIMN : LIMP;
        m   = qs[W][k];
        if (os[W][k] || m > lim) m = lim;
        inv[k] <= cs[W].singular ? as[W][k] : (gs[W][k] ? -m : m);
      end
    end
  end
endmodule

// File: hw/rtl/matrix_inverse_3x3_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core
// 3x3 signed fixed-point matrix inverse by adjugate, fully pipelined
// ----------------------------------------------------------------------------
// Accepts one matrix word per cycle when the output side does not stall,
// and returns one result word per matrix, in order. The divider resolves
// one quotient bit per stage for ELEM_WIDTH stages in each of its nine
// lanes; cofactors take two stages and the determinant three. The whole
// pipe advances together: it holds while the output register is full and
// not taken, so nothing is lost or repeated.
// ok clear marks a singular matrix, with the saturated adjugate on the
// element outputs. The singular threshold register sits at byte address 0.
module matrix_inverse_3x3_core #(
  parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH,
  parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  mi3_in_if.sink                      in_ch,
  mi3_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mi3_pkg::APB_AW-1:0]  paddr,
  input  logic [mi3_pkg::APB_DW-1:0]  pwdata,
  output logic [mi3_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  localparam int W = ELEM_WIDTH;
  localparam int N = mi3_pkg::NUM_ELEMS;

  logic                            en;
  logic [mi3_pkg::THR_WIDTH-1:0]   thr;
  logic signed [W-1:0]             e [N];
  logic                            cof_valid;
  logic signed [2*W:0]             cof [N];
  logic signed [W-1:0]             row0 [3];
  mi3_pkg::det_ctl_t               dctl;
  logic [3*W-1:0]                  dmag;
  logic [2*W-1:0]                  amag [N];
  logic                            aneg [N];
  logic [W-1:0]                    adj [N];
  logic [W-1:0]                    inv [N];

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  assign e[0] = in_ch.m00;
  assign e[1] = in_ch.m01;
  assign e[2] = in_ch.m02;
  assign e[3] = in_ch.m10;
  assign e[4] = in_ch.m11;
  assign e[5] = in_ch.m12;
  assign e[6] = in_ch.m20;
  assign e[7] = in_ch.m21;
  assign e[8] = in_ch.m22;

  assign out_ch.inv00 = inv[0];
  assign out_ch.inv01 = inv[1];
  assign out_ch.inv02 = inv[2];
  assign out_ch.inv10 = inv[3];
  assign out_ch.inv11 = inv[4];
  assign out_ch.inv12 = inv[5];
  assign out_ch.inv20 = inv[6];
  assign out_ch.inv21 = inv[7];
  assign out_ch.inv22 = inv[8];

  mi3_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  mi3_cof #(.W(W)) u_cof (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_ch.valid),
    .e         (e),
    .out_valid (cof_valid),
    .cof       (cof),
    .row0      (row0)
  );

  mi3_det #(.W(W), .F(FRAC_BITS)) u_det (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (cof_valid),
    .cof      (cof),
    .row0     (row0),
    .thr      (thr),
    .ctl      (dctl),
    .dmag     (dmag),
    .amag     (amag),
    .aneg     (aneg),
    .adj      (adj)
  );

  mi3_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .ctl       (dctl),
    .dmag      (dmag),
    .amag      (amag),
    .aneg      (aneg),
    .adj       (adj),
    .out_valid (out_ch.valid),
    .ok        (out_ch.ok),
    .inv       (inv)
  );

`ifndef ASSERT_OFF
  a_reset_clears : assert property (@(posedge clk)
    rst |=> !out_ch.valid && !cof_valid && !dctl.valid)
    else $error("pipeline valid set after reset");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(cof_valid) && $stable(dctl.valid))
    else $error("pipeline moved while stalled");

  a_zero_det_singular : assert property (@(posedge clk) disable iff (rst)
    dctl.valid && dmag == '0 |-> dctl.singular)
    else $error("zero determinant not flagged singular");
`endif
endmodule
